// File: src/lkvc_pkg.sv
// Shared types and constants of the LRU key-value cache.
`timescale 1ns / 1ps
`default_nettype none
package lkvc_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CFG_W = 5;

  localparam int DEFAULT_MAX_ENTRIES = 16;

  localparam logic [CFG_W-1:0] CAP_RESET  = 5'd16;
  localparam logic             MODE_GET   = 1'b0;
  localparam logic             MODE_SET   = 1'b1;
  localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

  typedef struct packed {
    logic                    mode;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } lkvc_in_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
  } lkvc_out_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic             cmp;
    logic [KEY_W-1:0] key;
    logic             apply;
    logic             shift_all;
  } lkvc_ctl_t;

endpackage
`default_nettype wire

// File: src/lkvc_cell.sv
// One storage cell of the recency-ordered chain.
`timescale 1ns / 1ps
`default_nettype none
module lkvc_cell import lkvc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lkvc_ctl_t        ctl,
  input  wire logic             valid_i,
  input  wire logic [KEY_W-1:0] prev_key,
  input  wire logic [VAL_W-1:0] prev_value,
  input  wire logic             sel_in,
  input  wire logic [VAL_W-1:0] acc_in,
  output logic      [KEY_W-1:0] key_o,
  output logic      [VAL_W-1:0] value_o,
  output logic                  sel_out,
  output logic      [VAL_W-1:0] acc_out
);

  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;
  logic             match_r;
  logic             shift;

  // Match here or in any older cell: this cell takes its younger neighbor.
  assign sel_out = match_r | sel_in;
  assign acc_out = acc_in | (match_r ? value_r : '0);
  assign shift   = ctl.apply & (ctl.shift_all | sel_out);
  assign key_o   = key_r;
  assign value_o = value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctl.cmp) begin
      match_r <= valid_i && (key_r == ctl.key);
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key_r   <= prev_key;
      value_r <= prev_value;
    end
  end

endmodule
`default_nettype wire

// File: src/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Input channel: drive in_data (mode, key, value) and raise start; the
//   transfer happens at a clock edge with start high and busy low.
//   mode get looks the key up; mode set inserts or updates it.
//   Result channel: for each get, out_strobe is high for exactly one cycle
//   with out_data (hit, read_value); a miss returns read_value of all ones.
//   A set produces no result. The receiver cannot stall the block.
//   Configuration: cfg_we with cfg_wdata writes capacity; write it only
//   while the block is idle. Capacity zero acts as one, values above
//   MAX_ENTRIES saturate.
// Timing:
//   The cycle of an item's transfer compares the key in every cell at once;
//   the next (busy high) shifts the chain and updates the fill count. A
//   result appears in the cycle after that. No new item is taken while
//   busy is high; the compare-then-shift sequence through the cell chain
//   sets that limit.
// Reset:
//   rst_n (synchronous, active low) empties the cache and sets capacity to
//   16. No clearing pass is needed since validity follows the fill count.
// Cell 0 holds the most recent entry; valid entries fill cells 0..count-1.
module lru_key_value_cache import lkvc_pkg::*; #(
  parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire lkvc_in_t         in_data,
  output logic                  out_strobe,
  output lkvc_out_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int EW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic             busy_r;
  lkvc_in_t         op_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CFG_W-1:0] cap_r;
  logic             out_strobe_r;
  lkvc_out_t        out_r, out_nxt;

  lkvc_ctl_t        ctl;
  logic             accept;
  logic             hit;
  logic [KEY_W-1:0] head_key;
  logic [VAL_W-1:0] head_value;
  logic [EW-1:0]    cap_ext, eff_cap, count_ext;

  logic [KEY_W-1:0] cell_key   [MAX_ENTRIES];
  logic [VAL_W-1:0] cell_value [MAX_ENTRIES];
  logic             cell_valid [MAX_ENTRIES];
  logic             sel        [MAX_ENTRIES+1];
  logic [VAL_W-1:0] acc        [MAX_ENTRIES+1];

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // Compare during the transfer cycle, shift during the busy cycle.
  assign hit           = sel[0];
  assign ctl.cmp       = accept;
  assign ctl.key       = in_data.key;
  assign ctl.apply     = busy_r;
  assign ctl.shift_all = (op_r.mode == MODE_SET) && !hit;

  // Head of the chain: new entry on set, the hit entry moved up on get.
  assign head_key   = op_r.key;
  assign head_value = (op_r.mode == MODE_SET) ? op_r.value : acc[0];

  assign sel[MAX_ENTRIES] = 1'b0;
  assign acc[MAX_ENTRIES] = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    assign cell_valid[i] = count_r > CNT_W'(i);
    if (i == 0) begin : g_head
      lkvc_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .valid_i   (cell_valid[i]),
        .prev_key  (head_key),
        .prev_value(head_value),
        .sel_in    (sel[i+1]),
        .acc_in    (acc[i+1]),
        .key_o     (cell_key[i]),
        .value_o   (cell_value[i]),
        .sel_out   (sel[i]),
        .acc_out   (acc[i])
      );
    end else begin : g_body
      lkvc_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .valid_i   (cell_valid[i]),
        .prev_key  (cell_key[i-1]),
        .prev_value(cell_value[i-1]),
        .sel_in    (sel[i+1]),
        .acc_in    (acc[i+1]),
        .key_o     (cell_key[i]),
        .value_o   (cell_value[i]),
        .sel_out   (sel[i]),
        .acc_out   (acc[i])
      );
    end
  end

  // Clamp capacity into 1..MAX_ENTRIES.
  assign cap_ext   = EW'(cap_r);
  assign count_ext = EW'(count_r);
  always_comb begin
    priority if (cap_r == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > EW'(MAX_ENTRIES)) begin
      eff_cap = EW'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Fill count: a set that hits drops and re-inserts, a set that misses
  // evicts the oldest cell (it falls off the end of the shift) when full.
  always_comb begin
    count_nxt = count_r;
    if (busy_r && (op_r.mode == MODE_SET)) begin
      if (hit) begin
        if ((count_ext - EW'(1)) >= eff_cap) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end else if (count_ext < eff_cap) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    out_nxt.hit        = hit;
    out_nxt.read_value = hit ? acc[0] : MISS_VALUE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      count_r      <= '0;
      cap_r        <= CAP_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= accept;
      count_r      <= count_nxt;
      out_strobe_r <= busy_r && (op_r.mode == MODE_GET);
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // Payload registers: hold the transfer, advance the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_data;
    end
    if (busy_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule
`default_nettype wire

// File: src/lkvc_checker.sv
// Port-level checker for the LRU key-value cache, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lkvc_checker import lkvc_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire lkvc_in_t  in_data,
  input wire logic      out_strobe,
  input wire lkvc_out_t out_data
);

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transfer not followed by busy");

  a_busy_one : assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_strobe_get : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(start && !busy, 2) && ($past(in_data.mode, 2) == MODE_GET)))
    else $error("result without a get two cycles earlier");

  a_get_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.mode == MODE_GET)) |=> ##1 out_strobe)
    else $error("get without a result");

  a_miss_value : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.hit) |-> (out_data.read_value == MISS_VALUE))
    else $error("miss result with a value other than all ones");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_strobe(out_strobe),
  .out_data  (out_data)
);
`default_nettype wire

// File: verif/lkvc_checker.sv
// Checker for the LRU key-value cache: recency predictor and lookup scoreboard.
`timescale 1ns / 1ps
module lkvc_scoreboard import lkvc_pkg::*; #(
  parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  lkvc_in_t         in_data,
  input  logic             out_strobe,
  input  lkvc_out_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               mismatches,
  output int               lookups_pending
);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } line_t;

  // Index 0 is the most recent line.
  line_t            recency_q[$];
  lkvc_out_t        lookup_q[$];
  logic [CFG_W-1:0] capacity_reg = CAP_RESET;
  int               err_count = 0;

  // Apply one access to the model; returns 1 when it yields a lookup result.
  function automatic bit apply_access(input lkvc_in_t acc, output lkvc_out_t res);
    int    found;
    int    limit;
    line_t ln;
    found = -1;
    res   = '0;
    for (int i = 0; i < recency_q.size(); i++) begin
      if (recency_q[i].key == acc.key) begin
        found = i;
        break;
      end
    end
    if (acc.mode == MODE_GET) begin
      if (found < 0) begin
        res.hit        = 1'b0;
        res.read_value = MISS_VALUE;
      end else begin
        ln = recency_q[found];
        recency_q.delete(found);
        recency_q.insert(0, ln);
        res.hit        = 1'b1;
        res.read_value = ln.value;
      end
      return 1'b1;
    end
    if (found >= 0) recency_q.delete(found);
    limit = int'(capacity_reg);
    if (limit == 0) limit = 1;
    if (limit > MAX_ENTRIES) limit = MAX_ENTRIES;
    if (recency_q.size() >= limit) recency_q.delete(recency_q.size() - 1);
    ln.key   = acc.key;
    ln.value = acc.value;
    recency_q.insert(0, ln);
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    lkvc_out_t want;
    if (!rst_n) begin
      recency_q.delete();
      lookup_q.delete();
      capacity_reg = CAP_RESET;
    end else begin
      // Results belong to earlier transfers, so check before taking this one.
      if (out_strobe) begin
        if (lookup_q.size() == 0) begin
          if (err_count < 10)
            $display("%0t: result without pending lookup: hit=%0b value=%h",
                     $realtime, out_data.hit, out_data.read_value);
          err_count++;
        end else begin
          want = lookup_q[0];
          lookup_q.delete(0);
          if (out_data.hit !== want.hit || out_data.read_value !== want.read_value) begin
            if (err_count < 10)
              $display("%0t: lookup mismatch: expected hit=%0b value=%h, got hit=%0b value=%h",
                       $realtime, want.hit, want.read_value,
                       out_data.hit, out_data.read_value);
            err_count++;
          end
        end
      end
      if (start && !busy) begin
        if (apply_access(in_data, want)) lookup_q.insert(lookup_q.size(), want);
      end
      if (cfg_we) capacity_reg = cfg_wdata;
    end
    mismatches      <= err_count;
    lookups_pending <= lookup_q.size();
  end

endmodule

// File: verif/tb_lru_key_value_cache.sv
// Testbench top for the LRU key-value cache: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_lru_key_value_cache import lkvc_pkg::*;;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  lkvc_in_t         in_data = '0;
  logic             out_strobe;
  lkvc_out_t        out_data;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  int mismatches;
  int lookups_pending;

  // Sender idling: bursts of back-to-back transfers separated by gaps.
  bit idle_on   = 1'b1;
  int burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lru_key_value_cache i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  lkvc_scoreboard i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_data         (in_data),
    .out_strobe      (out_strobe),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .lookups_pending (lookups_pending)
  );

  // Present one access and hold it until the block takes it. busy is read
  // right after the edge, so it is the value the block saw at that edge.
  task automatic send_access(input logic mode, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] val);
    lkvc_in_t acc;
    int       gap;
    acc.mode  = mode;
    acc.key   = key;
    acc.value = val;
    start   <= 1'b1;
    in_data <= acc;
    do @(posedge clk); while (busy);
    // Transfer done at this edge; keep start high for the next one or
    // drop it for a gap.
    if (idle_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(10, 0);
        gap = ($urandom_range(7, 0) == 0) ? $urandom_range(25, 6) : $urandom_range(4, 1);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold the sender until every lookup has returned, then let the last
  // set drain through the shift cycle, which returns nothing.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (lookups_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Capacity writes only happen with the block idle.
  task automatic write_capacity(input logic [CFG_W-1:0] cap);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] caps[9];
    logic [KEY_W-1:0] key_pool[40];
    logic [KEY_W-1:0] k;
    int               eff;
    int               pool_n;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-cache miss, key and value extremes, update in place.
    idle_on = 1'b0;
    send_access(MODE_GET, 32'h0000_0000, 32'h1234_5678);
    send_access(MODE_SET, 32'h8000_0000, 32'h7fff_ffff);
    send_access(MODE_SET, 32'h7fff_ffff, 32'h8000_0000);
    send_access(MODE_SET, 32'h0000_0000, 32'h0000_0000);
    send_access(MODE_SET, 32'hffff_ffff, 32'hffff_ffff);  // hit that looks like a miss value
    send_access(MODE_GET, 32'h8000_0000, 32'h0);
    send_access(MODE_GET, 32'h7fff_ffff, 32'hffff_ffff);
    send_access(MODE_GET, 32'hffff_ffff, 32'h0);
    send_access(MODE_SET, 32'h0000_0000, 32'h0000_0005);
    send_access(MODE_GET, 32'h0000_0000, 32'h0);
    send_access(MODE_GET, 32'h0000_3039, 32'h0);

    // Capacity one, lowered below the fill count: each set evicts once.
    write_capacity(5'd1);
    send_access(MODE_SET, 32'h0000_00a1, 32'h1111_1111);
    send_access(MODE_SET, 32'h0000_00b2, 32'h2222_2222);
    send_access(MODE_GET, 32'h8000_0000, 32'h0);
    send_access(MODE_GET, 32'h0000_00b2, 32'h0);

    // Capacity zero behaves as one.
    write_capacity(5'd0);
    send_access(MODE_SET, 32'h0000_00c3, 32'h3333_3333);
    send_access(MODE_GET, 32'h0000_00c3, 32'h0);

    // Capacity two, below the fill count: a get refreshes recency, then a set evicts the oldest.
    write_capacity(5'd2);
    send_access(MODE_SET, 32'h0000_0001, 32'haaaa_0001);
    send_access(MODE_SET, 32'h0000_0002, 32'haaaa_0002);
    send_access(MODE_GET, 32'h0000_0001, 32'h0);
    send_access(MODE_SET, 32'h0000_0003, 32'haaaa_0003);
    send_access(MODE_GET, 32'h0000_0002, 32'h0);
    send_access(MODE_GET, 32'h0000_0001, 32'h0);

    // Random phases over several capacities, saturation and the extremes
    // among them. Keys mostly come from a pool sized near the capacity so
    // that hits, refreshes and evictions all happen.
    caps = '{5'd16, 5'd31, 5'd3, 5'd1, 5'd8, 5'd0, 5'd17, 5'd2, 5'd0};
    caps[8] = CFG_W'($urandom_range(31, 0));
    for (int ph = 0; ph < 9; ph++) begin
      write_capacity(caps[ph]);
      idle_on = (ph != 2);
      burst_left = 0;
      eff = (caps[ph] == 0) ? 1 : ((caps[ph] > 16) ? 16 : int'(caps[ph]));
      pool_n = eff + $urandom_range(eff + 2, 1);
      if (pool_n > 40) pool_n = 40;
      foreach (key_pool[i]) key_pool[i] = $urandom();
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      for (int n = 0; n < 50; n++) begin
        if (ph == 4 && n == 25) drain();
        k = ($urandom_range(99, 0) < 85) ? key_pool[$urandom_range(pool_n - 1, 0)]
                                         : $urandom();
        send_access(($urandom_range(99, 0) < 55) ? MODE_GET : MODE_SET, k, $urandom());
      end
    end

    // Wait out every outstanding lookup, then give the verdict.
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && lookups_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin : watchdog
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
